// ----- rtl/core/assert_macros.svh -----
// Assertion macros used by set_assoc_cookie_cache.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/sacc_pkg.sv -----
package sacc_pkg;

  localparam int SET_COUNT  = 1024;
  localparam int WAY_COUNT  = 2;
  localparam int SET_W      = $clog2(SET_COUNT);
  localparam int WAY_W      = (WAY_COUNT > 1) ? $clog2(WAY_COUNT) : 1;
  localparam int KEY_W      = 64;
  localparam int COOKIE_W   = 32;
  localparam int STRIDE_W   = 16;
  localparam int BYTE_W     = 8;
  localparam int HASH_SHIFT = 5;
  localparam int HASH_STEPS = 3;
  localparam int STEP_W     = 2;
  localparam int PADDR_W    = 3;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HASH,
    ST_READ,
    ST_UPDATE
  } state_t;

  typedef enum logic {
    REG_COOKIE_START  = 1'b0,
    REG_COOKIE_STRIDE = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic [KEY_W-1:0]    key;
    logic [COOKIE_W-1:0] value;
  } entry_t;

  typedef entry_t [WAY_COUNT-1:0] row_t;

endpackage

// ----- rtl/core/set_assoc_cookie_cache.sv -----
// From the accepting edge to the result strobe: 3 hash steps on the shared adder, a
// set-memory read, a compare and write-back, and the output register.
// One word at a time: the next start is taken while the strobe is shown.
// Reset: rst_n is synchronous; afterwards busy stays high while all 1024 sets of the
// set memory are cleared one set per cycle. Configuration writes are taken during that pass.
// Results cannot be stalled: each is shown on out_valid for exactly one cycle.
`include "assert_macros.svh"

module set_assoc_cookie_cache (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic [sacc_pkg::KEY_W-1:0]       in_lookup_key,
  output logic                             out_valid,
  output logic [sacc_pkg::COOKIE_W-1:0]    out_cookie,
  output logic                             out_new_entry,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [sacc_pkg::PADDR_W-1:0]     paddr,
  input  logic [31:0]                      pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready
);

  sacc_pkg::state_t state_r, state_nxt;

  logic [sacc_pkg::SET_W-1:0]    clr_cnt_r;
  logic [sacc_pkg::STEP_W-1:0]   step_r;
  logic [sacc_pkg::SET_W-1:0]    set_r;
  logic [sacc_pkg::KEY_W-1:0]    key_r;
  logic [sacc_pkg::COOKIE_W-1:0] next_cookie_r;
  logic [sacc_pkg::COOKIE_W-1:0] start_r;
  logic [sacc_pkg::STRIDE_W-1:0] stride_r;
  sacc_pkg::row_t                rd_row_r;
  logic                          out_valid_r;
  logic [sacc_pkg::COOKIE_W-1:0] out_cookie_r;
  logic                          out_new_r;

  sacc_pkg::row_t mem [sacc_pkg::SET_COUNT];

  logic [sacc_pkg::COOKIE_W-1:0] alu_a, alu_b, alu_sum;
  logic [sacc_pkg::SET_W-1:0]    h_x32, h_mul;
  logic [sacc_pkg::BYTE_W-1:0]   hash_byte;
  logic                          mem_we;
  logic [sacc_pkg::SET_W-1:0]    mem_wr_addr;
  sacc_pkg::row_t                mem_wr_row;
  logic                          hit_found;
  logic [sacc_pkg::WAY_W-1:0]    hit_way;
  logic [sacc_pkg::WAY_W-1:0]    shift_last;
  logic [sacc_pkg::COOKIE_W-1:0] result_cookie;
  logic                          accept;
  logic                          cfg_wr;

  assign accept = start && !busy;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign pready = 1'b1;

  always_comb begin
    case (sacc_pkg::cfg_reg_t'(paddr[2]))
      sacc_pkg::REG_COOKIE_START:  prdata = start_r;
      sacc_pkg::REG_COOKIE_STRIDE: prdata = 32'(stride_r);
      default:                     prdata = '0;
    endcase
  end

  // Hash step: h*31 + byte, kept to the set index width.
  assign h_x32 = set_r << sacc_pkg::HASH_SHIFT;
  assign h_mul = h_x32 - set_r;

  always_comb begin
    case (step_r)
      2'd0:    hash_byte = key_r[23:16];
      2'd1:    hash_byte = key_r[15:8];
      default: hash_byte = key_r[7:0];
    endcase
  end

  always_comb begin
    hit_found = 1'b0;
    hit_way   = '0;
    for (int w = sacc_pkg::WAY_COUNT - 1; w >= 0; w--) begin
      if (rd_row_r[w].value != '0 && rd_row_r[w].key == key_r) begin
        hit_found = 1'b1;
        hit_way   = sacc_pkg::WAY_W'(w);
      end
    end
  end

  assign shift_last = hit_found ? hit_way : sacc_pkg::WAY_W'(sacc_pkg::WAY_COUNT - 1);

  always_comb begin
    case (state_r)
      sacc_pkg::ST_IDLE: state_nxt = start ? sacc_pkg::ST_HASH : sacc_pkg::ST_IDLE;
      sacc_pkg::ST_CLEAR: begin
        state_nxt = (clr_cnt_r == sacc_pkg::SET_W'(sacc_pkg::SET_COUNT - 1)) ?
                    sacc_pkg::ST_IDLE : sacc_pkg::ST_CLEAR;
      end
      sacc_pkg::ST_HASH: begin
        state_nxt = (step_r == sacc_pkg::STEP_W'(sacc_pkg::HASH_STEPS - 1)) ?
                    sacc_pkg::ST_READ : sacc_pkg::ST_HASH;
      end
      sacc_pkg::ST_READ:   state_nxt = sacc_pkg::ST_UPDATE;
      sacc_pkg::ST_UPDATE: state_nxt = sacc_pkg::ST_IDLE;
      default:             state_nxt = sacc_pkg::ST_CLEAR;
    endcase
  end

  always_comb begin
    busy          = 1'b1;
    alu_a         = sacc_pkg::COOKIE_W'(h_mul);
    alu_b         = sacc_pkg::COOKIE_W'(hash_byte);
    mem_we        = 1'b0;
    mem_wr_addr   = set_r;
    mem_wr_row    = rd_row_r;
    result_cookie = '0;
    case (state_r)
      sacc_pkg::ST_IDLE: busy = 1'b0;
      sacc_pkg::ST_CLEAR: begin
        mem_we      = 1'b1;
        mem_wr_addr = clr_cnt_r;
        mem_wr_row  = '0;
      end
      sacc_pkg::ST_UPDATE: begin
        alu_a         = next_cookie_r;
        alu_b         = sacc_pkg::COOKIE_W'(stride_r);
        result_cookie = hit_found ? rd_row_r[hit_way].value : alu_sum;
        mem_we        = 1'b1;
        for (int w = 1; w < sacc_pkg::WAY_COUNT; w++) begin
          if (sacc_pkg::WAY_W'(w) <= shift_last) begin
            mem_wr_row[w] = rd_row_r[w-1];
          end
        end
        mem_wr_row[0].key   = key_r;
        mem_wr_row[0].value = result_cookie;
      end
      default: begin
      end
    endcase
  end

  assign alu_sum = alu_a + alu_b;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wr_addr] <= mem_wr_row;
    end
    rd_row_r <= mem[set_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= sacc_pkg::ST_CLEAR;
      clr_cnt_r     <= '0;
      step_r        <= '0;
      start_r       <= sacc_pkg::COOKIE_W'(1);
      stride_r      <= sacc_pkg::STRIDE_W'(1);
      next_cookie_r <= sacc_pkg::COOKIE_W'(1);
      out_valid_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= (state_r == sacc_pkg::ST_UPDATE);
      if (state_r == sacc_pkg::ST_CLEAR) begin
        clr_cnt_r <= clr_cnt_r + sacc_pkg::SET_W'(1);
      end
      if (accept) begin
        step_r <= '0;
      end else if (state_r == sacc_pkg::ST_HASH) begin
        step_r <= step_r + sacc_pkg::STEP_W'(1);
      end
      if (cfg_wr) begin
        case (sacc_pkg::cfg_reg_t'(paddr[2]))
          sacc_pkg::REG_COOKIE_START: begin
            start_r       <= pwdata;
            next_cookie_r <= pwdata;
          end
          sacc_pkg::REG_COOKIE_STRIDE: stride_r <= pwdata[sacc_pkg::STRIDE_W-1:0];
          default: begin
          end
        endcase
      end else if (state_r == sacc_pkg::ST_UPDATE && !hit_found) begin
        next_cookie_r <= alu_sum;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      key_r <= in_lookup_key;
      set_r <= sacc_pkg::SET_W'(in_lookup_key[31:24]);
    end else if (state_r == sacc_pkg::ST_HASH) begin
      set_r <= alu_sum[sacc_pkg::SET_W-1:0];
    end
    if (state_r == sacc_pkg::ST_UPDATE) begin
      out_cookie_r <= result_cookie;
      out_new_r    <= !hit_found;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_cookie    = out_cookie_r;
  assign out_new_entry = out_new_r;

  `ASSERT_SAME(a_strobe_after_update, out_valid, $past(state_r == sacc_pkg::ST_UPDATE),
               "result strobe without a preceding update cycle")
  `ASSERT_NEXT(a_accept_starts_hash, start && !busy, state_r == sacc_pkg::ST_HASH,
               "accepted word did not start the hash sequence")
  `ASSERT_SAME(a_new_cookie_is_counter, out_valid && out_new_entry,
               out_cookie == next_cookie_r,
               "allocated cookie differs from the cookie counter")

endmodule
